// File: hdl/qsrc_pkg.sv
// Shared types and action codes for the quadrature step rotation counter.
package qsrc_pkg;

  localparam int unsigned SubW = 12;
  localparam int unsigned TotW = 16;

  typedef logic [SubW-1:0] steps_t;
  typedef logic [TotW-1:0] total_t;

  typedef enum logic [1:0] {
    ACT_EDGE_A = 2'd0,
    ACT_EDGE_B = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic       level_a;
    logic       level_b;
  } item_t;

  typedef struct packed {
    total_t             right_total;
    total_t             left_total;
    logic signed [15:0] position;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// File: hdl/qsrc_if.sv
// Valid/ready channel interfaces for input items and result items.
interface qsrc_in_if import qsrc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface qsrc_out_if import qsrc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/qsrc_in_stage.sv
// Input register stage for encoder items.
module qsrc_in_stage import qsrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsrc_in_if.sink    in_i,
  input  logic       advance_i,
  output stage_t     stage_o
);

  logic  valid_q;
  item_t item_q;

  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.payload;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// File: hdl/qsrc_step.sv
// Detent detection, rotation counting and position state.
module qsrc_step import qsrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stage_t  stage_i,
  input  logic    advance_i,
  input  steps_t  steps_per_rotation_i,
  output result_t result_o
);

  logic               a_armed_q, a_armed_d;
  logic               b_armed_q, b_armed_d;
  steps_t             right_det_q, right_det_d;
  steps_t             left_det_q, left_det_d;
  total_t             right_rot_q, right_rot_d;
  total_t             left_rot_q, left_rot_d;
  logic signed [15:0] pos_q, pos_d;

  steps_t right_inc;
  steps_t left_inc;
  total_t right_total;
  total_t left_total;
  logic   la;
  logic   lb;

  assign la        = stage_i.item.level_a;
  assign lb        = stage_i.item.level_b;
  assign right_inc = right_det_q + steps_t'(1);
  assign left_inc  = left_det_q + steps_t'(1);

  always_comb begin
    a_armed_d   = a_armed_q;
    b_armed_d   = b_armed_q;
    right_det_d = right_det_q;
    left_det_d  = left_det_q;
    right_rot_d = right_rot_q;
    left_rot_d  = left_rot_q;
    pos_d       = pos_q;
    right_total = '0;
    left_total  = '0;
    case (stage_i.item.action)
      ACT_EDGE_A: begin
        if (la && lb && b_armed_q) begin
          a_armed_d = 1'b0;
          b_armed_d = 1'b0;
          if (right_inc >= steps_per_rotation_i) begin
            right_det_d = '0;
            right_rot_d = right_rot_q + total_t'(1);
            pos_d       = pos_q + 16'sd1;
            right_total = right_rot_d;
          end else begin
            right_det_d = right_inc;
          end
        end else if (la && !lb) begin
          a_armed_d = 1'b1;
        end
      end
      ACT_EDGE_B: begin
        if (la && lb && a_armed_q) begin
          a_armed_d = 1'b0;
          b_armed_d = 1'b0;
          if (left_inc >= steps_per_rotation_i) begin
            left_det_d = '0;
            left_rot_d = left_rot_q + total_t'(1);
            pos_d      = pos_q - 16'sd1;
            left_total = left_rot_d;
          end else begin
            left_det_d = left_inc;
          end
        end else if (lb && !la) begin
          b_armed_d = 1'b1;
        end
      end
      ACT_CLEAR: begin
        right_det_d = '0;
        left_det_d  = '0;
        right_rot_d = '0;
        left_rot_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_armed_q   <= 1'b0;
      b_armed_q   <= 1'b0;
      right_det_q <= '0;
      left_det_q  <= '0;
      right_rot_q <= '0;
      left_rot_q  <= '0;
      pos_q       <= '0;
    end else if (advance_i && stage_i.valid) begin
      a_armed_q   <= a_armed_d;
      b_armed_q   <= b_armed_d;
      right_det_q <= right_det_d;
      left_det_q  <= left_det_d;
      right_rot_q <= right_rot_d;
      left_rot_q  <= left_rot_d;
      pos_q       <= pos_d;
    end
  end

  assign result_o.right_total = right_total;
  assign result_o.left_total  = left_total;
  assign result_o.position    = pos_d;

endmodule

// File: hdl/qsrc_out_stage.sv
// Result register stage driving the output channel.
module qsrc_out_stage import qsrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    result_i,
  qsrc_out_if.source out_o,
  output logic       take_o
);

  logic    valid_q;
  result_t result_q;

  assign take_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = result_q;

endmodule

// File: hdl/quadrature_step_rotation_counter_core.sv
// Quadrature step rotation counter: input register, detent logic, result register.
// Takes one encoder item per clock unless the output side stalls, and returns one
// result per item. An accepted item waits in the input register; the detent and
// rotation counters update as it moves into the result register, which drives the
// output, and the result is taken when the output side is ready. A stalled output
// holds its result while one further item waits in the input register. The
// resolution register takes effect for items processed after the write.
module quadrature_step_rotation_counter_core import qsrc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  steps_t       cfg_wdata_i,
  qsrc_in_if.sink      in_i,
  qsrc_out_if.source   out_o
);

  steps_t  steps_q;
  stage_t  stage;
  result_t result;
  logic    advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= steps_t'(1);
    end else if (cfg_we_i) begin
      steps_q <= cfg_wdata_i;
    end
  end

  qsrc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  qsrc_step u_step (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .stage_i              (stage),
    .advance_i            (advance),
    .steps_per_rotation_i (steps_q),
    .result_o             (result)
  );

  qsrc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (stage.valid),
    .result_i (result),
    .out_o    (out_o),
    .take_o   (advance)
  );

endmodule

// File: hdl/qsrc_checker.sv
// Port checker for the rotation counter and its bind to the top level.
module qsrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_right_total_i,
  input logic [15:0] out_left_total_i,
  input logic [15:0] out_position_i
);

  logic [15:0] last_pos_q;
  logic [15:0] pos_up;
  logic [15:0] pos_down;
  logic        out_fire;

  assign out_fire = out_valid_i && out_ready_i;
  assign pos_up   = last_pos_q + 16'd1;
  assign pos_down = last_pos_q - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
    end else if (out_fire) begin
      last_pos_q <= out_position_i;
    end
  end

  a_right_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (out_right_total_i != 16'd0) |-> out_position_i == pos_up)
    else $error("right rotation without position step up");

  a_left_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (out_left_total_i != 16'd0) |-> out_position_i == pos_down)
    else $error("left rotation without position step down");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (out_right_total_i == 16'd0) && (out_left_total_i == 16'd0)
    |-> (out_position_i == last_pos_q) || (out_position_i == pos_up) ||
        (out_position_i == pos_down))
    else $error("position moved by more than one step");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

endmodule

bind quadrature_step_rotation_counter_core qsrc_checker u_qsrc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_right_total_i (out_o.payload.right_total),
  .out_left_total_i  (out_o.payload.left_total),
  .out_position_i    (out_o.payload.position)
);

// File: bench/tb.sv
// Self-checking testbench for the quadrature step rotation counter core.
`timescale 1ns / 1ps

module tb;
  import qsrc_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we;
  steps_t cfg_wdata;

  qsrc_in_if  in_ch ();
  qsrc_out_if out_ch ();

  quadrature_step_rotation_counter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // encoder state as the block should hold it
  steps_t             res_steps;
  logic               a_mark;
  logic               b_mark;
  steps_t             right_sub;
  steps_t             left_sub;
  total_t             right_rot;
  total_t             left_rot;
  logic signed [15:0] net_pos;

  result_t     pending_results [$];
  row_t        dir_tab [$];
  bit          idle_on;
  int unsigned errors;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic item_t make_item(logic [1:0] action, logic a, logic b);
    item_t it;
    it.action  = action;
    it.level_a = a;
    it.level_b = b;
    return it;
  endfunction

  function automatic row_t row(logic [1:0] action, int a, int b, int typed,
                               int rt, int lt, int pos);
    row_t r;
    r.it                = make_item(action, 1'(a), 1'(b));
    r.typed             = 1'(typed);
    r.res.right_total   = total_t'(rt);
    r.res.left_total    = total_t'(lt);
    r.res.position      = 16'(pos);
    return r;
  endfunction

  function automatic result_t advance_encoder(item_t it);
    result_t r;
    r = '0;
    case (it.action)
      ACT_EDGE_A: begin
        if (it.level_a && it.level_b && b_mark) begin
          a_mark    = 1'b0;
          b_mark    = 1'b0;
          right_sub = right_sub + 1'b1;
          if (right_sub >= res_steps) begin
            right_sub     = '0;
            right_rot     = right_rot + 1'b1;
            net_pos       = net_pos + 16'sd1;
            r.right_total = right_rot;
          end
        end else if (it.level_a && !it.level_b) begin
          a_mark = 1'b1;
        end
      end
      ACT_EDGE_B: begin
        if (it.level_a && it.level_b && a_mark) begin
          a_mark   = 1'b0;
          b_mark   = 1'b0;
          left_sub = left_sub + 1'b1;
          if (left_sub >= res_steps) begin
            left_sub     = '0;
            left_rot     = left_rot + 1'b1;
            net_pos      = net_pos - 16'sd1;
            r.left_total = left_rot;
          end
        end else if (it.level_b && !it.level_a) begin
          b_mark = 1'b1;
        end
      end
      ACT_CLEAR: begin
        right_sub = '0;
        left_sub  = '0;
        right_rot = '0;
        left_rot  = '0;
      end
      default: ;
    endcase
    r.position = net_pos;
    return r;
  endfunction

  // call at a falling edge; returns at a falling edge after acceptance
  task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
    result_t pred;
    while (idle_on && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = advance_encoder(it);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic send_plain(input item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_steps(input steps_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    res_steps = v;
  endtask

  // mostly clean detents with bounce on the arming edge, some clears and noise
  task automatic run_burst(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned bounce;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        bounce = $urandom_range(1, 2);
        repeat (bounce) send_plain(make_item(ACT_EDGE_B, 1'b0, 1'b1));
        send_plain(make_item(ACT_EDGE_A, 1'b1, 1'b1));
        sent += bounce + 1;
      end else if (pick < 70) begin
        bounce = $urandom_range(1, 2);
        repeat (bounce) send_plain(make_item(ACT_EDGE_A, 1'b1, 1'b0));
        send_plain(make_item(ACT_EDGE_B, 1'b1, 1'b1));
        sent += bounce + 1;
      end else if (pick < 73) begin
        send_plain(make_item(ACT_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1))));
        sent++;
      end else begin
        send_plain(make_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                             1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !idle_on || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: right %0d left %0d position %0d",
                 $time, got.right_total, got.left_total, got.position);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.right_total !== want.right_total) begin
          $display("%0t: right_total expected %0d actual %0d",
                   $time, want.right_total, got.right_total);
          errors++;
        end
        if (got.left_total !== want.left_total) begin
          $display("%0t: left_total expected %0d actual %0d",
                   $time, want.left_total, got.left_total);
          errors++;
        end
        if (got.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d",
                   $time, want.position, got.position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    idle_on       = 1'b1;
    errors        = 0;
    quiet_cycles  = 0;
    res_steps     = steps_t'(1);
    a_mark        = 1'b0;
    b_mark        = 1'b0;
    right_sub     = '0;
    left_sub      = '0;
    right_rot     = '0;
    left_rot      = '0;
    net_pos       = '0;

    dir_tab.push_back(row(ACT_EDGE_A, 1, 1, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_B, 0, 1, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 1, 1, 1, 1, 0, 1));
    dir_tab.push_back(row(ACT_EDGE_A, 1, 0, 1, 0, 0, 1));
    dir_tab.push_back(row(ACT_EDGE_B, 1, 1, 1, 0, 1, 0));
    dir_tab.push_back(row(ActUnused,  1, 1, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_B, 0, 1, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 0, 0, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 0, 1, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_B, 1, 0, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_B, 0, 0, 1, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 1, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_CLEAR,  0, 0, 1, 0, 0, 1));
    dir_tab.push_back(row(ACT_EDGE_B, 0, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 1, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_CLEAR,  1, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_B, 1, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(ActUnused,  0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_A, 1, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(ACT_EDGE_B, 1, 1, 0, 0, 0, 0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    set_steps(steps_t'(0));
    run_burst(150);

    set_steps(steps_t'(4095));
    run_burst(200);
    set_steps(steps_t'(3));
    run_burst(120);
    drain();
    run_burst(130);
    repeat (4) begin
      set_steps(steps_t'($urandom_range(1, 8)));
      run_burst(150);
    end
    set_steps(steps_t'($urandom_range(4095)));
    run_burst(200);
    idle_on = 1'b0;
    set_steps(steps_t'(1));
    run_burst(200);
    idle_on = 1'b1;
    set_steps(steps_t'($urandom_range(2, 5)));
    run_burst(200);

    drain();
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/qsrc_pkg.sv
hdl/qsrc_if.sv
hdl/qsrc_in_stage.sv
hdl/qsrc_step.sv
hdl/qsrc_out_stage.sv
hdl/quadrature_step_rotation_counter_core.sv
hdl/qsrc_checker.sv
bench/tb.sv
